// ----- rtl/sql_pkg.sv -----
// ----------------------------------------------------------------------------
// sql_pkg: shared types and constants
// Sizes, request and status codes, and the structs passed between the cells,
// the reducer and the top level of the sorted list queue.
// ----------------------------------------------------------------------------
package sql_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int RED_FAN  = 8;

  function automatic int reduce_steps(input int n);
    int rem;
    int steps;
    rem   = n;
    steps = 0;
    while (rem > 1) begin
      rem   = (rem + RED_FAN - 1) / RED_FAN;
      steps = steps + 1;
    end
    return (steps < 1) ? 1 : steps;
  endfunction

  localparam int REDUCE_STEPS = reduce_steps(CAPACITY);
  localparam int STEP_W       = $clog2(REDUCE_STEPS + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_POP_MIN = 2'd1,
    KIND_POP_MAX = 2'd2,
    KIND_SEARCH  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_REDUCE
  } sql_state_t;

  // broadcast to every cell
  typedef struct packed {
    logic                      ins;
    logic                      pop_min;
    logic                      max;
    logic                      srch;
    logic signed [VALUE_W-1:0] key;
    logic        [CNT_W-1:0]   cnt;
  } cell_cmd_t;

  // one-hot contribution of a cell to the reduction
  typedef struct packed {
    logic                      hit;
    logic        [IDX_W-1:0]   pos;
    logic signed [VALUE_W-1:0] data;
  } red_t;

  localparam int RED_W = $bits(red_t);

  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    logic        [POS_W-1:0]   position;
    status_t                   status;
    logic        [COUNT_W-1:0] count;
  } result_t;

endpackage

// ----- rtl/sql_if.sv -----
// ----------------------------------------------------------------------------
// sql_if: request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface sql_in_if import sql_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [KIND_W-1:0]  kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface sql_out_if import sql_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  data;
  logic        [POS_W-1:0]    position;
  logic        [STATUS_W-1:0] status;
  logic        [COUNT_W-1:0]  count;

  modport source (output valid, data, position, status, count, input ready);
  modport sink   (input valid, data, position, status, count, output ready);
endinterface

// ----- rtl/sql_cell.sv -----
// ----------------------------------------------------------------------------
// sql_cell: one slot of the sorted row
// Holds one entry, compares it with the key and shifts with its neighbours.
// ----------------------------------------------------------------------------
module sql_cell import sql_pkg::*; (
  input  logic                      clk,
  input  cell_cmd_t                 cmd_i,
  input  logic        [IDX_W-1:0]   idx_i,
  input  logic signed [VALUE_W-1:0] left_entry_i,
  input  logic                      left_lt_i,
  input  logic signed [VALUE_W-1:0] right_entry_i,
  output logic signed [VALUE_W-1:0] entry_o,
  output logic                      lt_o,
  output red_t                      red_o
);

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  logic valid, below, eq, last;

  assign valid = CNT_W'(idx_i) < cmd_i.cnt;
  assign below = valid && (entry_r < cmd_i.key);
  assign eq    = valid && (entry_r == cmd_i.key);
  assign last  = (CNT_W'(idx_i) + CNT_W'(1)) == cmd_i.cnt;

  always_comb begin
    priority if (cmd_i.ins) begin
      priority if (below) begin
        entry_nxt = entry_r;
      end else if (left_lt_i) begin
        entry_nxt = cmd_i.key;
      end else begin
        entry_nxt = left_entry_i;
      end
    end else if (cmd_i.pop_min) begin
      entry_nxt = right_entry_i;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // pop largest: last entry; search: first match, equal here, strictly smaller on left
  always_comb begin
    red_o = '0;
    if (cmd_i.max && last) begin
      red_o.hit  = 1'b1;
      red_o.data = entry_r;
    end else if (cmd_i.srch && eq && left_lt_i) begin
      red_o.hit = 1'b1;
      red_o.pos = idx_i;
    end
  end

  assign entry_o = entry_r;
  assign lt_o    = below;

endmodule

// ----- rtl/sql_reduce.sv -----
// ----------------------------------------------------------------------------
// sql_reduce: registered OR reduction
// Folds the one-hot cell contributions, eight nodes per step, into node 0.
// ----------------------------------------------------------------------------
module sql_reduce import sql_pkg::*; (
  input  logic clk,
  input  logic load_i,
  input  red_t leaf_i [CAPACITY],
  output red_t root_o
);

  logic [RED_W-1:0] node_r [CAPACITY];

  for (genvar j = 0; j < CAPACITY; j++) begin : g_node
    logic [RED_W-1:0] part [RED_FAN];
    logic [RED_W-1:0] grp;

    for (genvar k = 0; k < RED_FAN; k++) begin : g_part
      if (j * RED_FAN + k < CAPACITY) begin : g_in
        assign part[k] = node_r[j * RED_FAN + k];
      end else begin : g_zero
        assign part[k] = '0;
      end
    end

    always_comb begin
      grp = '0;
      for (int k = 0; k < RED_FAN; k++) begin
        grp = grp | part[k];
      end
    end

    always_ff @(posedge clk) begin
      if (load_i) begin
        node_r[j] <= leaf_i[j];
      end else begin
        node_r[j] <= grp;
      end
    end
  end

  assign root_o = red_t'(node_r[0]);

endmodule

// ----- rtl/sorted_list_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_list_queue: sorted insertion priority queue
// Row of compare-and-shift cells keeping signed values in ascending order.
// ----------------------------------------------------------------------------
// Requests enter on in_ch (kind, value) and each gives one result item on
// out_ch (data, position, status, count), in request order.
// Insert and pop-smallest act on the cell row in the cycle they are taken:
// one item per cycle while out_ch keeps up.
// Pop-largest on a non-empty queue and search collect the selected cell
// through the OR reduction, eight nodes per step; no new request is taken
// while the reduction runs.
// A full insert is dropped with status full; a pop on an empty queue gives
// status empty and data zero; a search miss gives not found.
// Reset empties the queue at once; no clearing pass is needed.
// Results sit in an output register with one result stage behind it, so a
// new item is still taken while out_ch stalls; after that in_ch.ready drops
// until the receiver takes the waiting item.
// ----------------------------------------------------------------------------
module sorted_list_queue import sql_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  sql_in_if.sink           in_ch,
  sql_out_if.source        out_ch
);

  sql_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              is_max_r, is_max_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;

  kind_t     kind;
  logic      in_ready, acc, move, load, done, imm_take, full, empty;
  cell_cmd_t cmd;
  result_t   imm, red_res;
  red_t      red_root;

  logic signed [VALUE_W-1:0] entry [CAPACITY];
  logic                      lt    [CAPACITY];
  red_t                      leaves [CAPACITY];

  logic [CNT_W+COUNT_W-1:0] cnt_nxt_ext, cnt_cur_ext;
  logic [IDX_W+POS_W-1:0]   pos_ext;

  assign kind  = kind_t'(in_ch.kind);
  assign acc   = in_ch.valid && in_ready;
  assign move  = !out_valid_r || out_ch.ready;
  assign full  = occ_r == CNT_W'(CAPACITY);
  assign empty = occ_r == '0;

  assign load = acc && ((kind == KIND_POP_MAX && !empty) || kind == KIND_SEARCH);
  assign imm_take = acc && !load;

  // state machine: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (load) begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (step_r == STEP_W'(REDUCE_STEPS)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = !res_valid_r || move;
      S_REDUCE: done = step_r == STEP_W'(REDUCE_STEPS);
      default:  in_ready = 1'b0;
    endcase
  end

  assign step_nxt   = (state_r == S_REDUCE) ? step_r + STEP_W'(1) : '0;
  assign is_max_nxt = load ? (kind == KIND_POP_MAX) : is_max_r;

  always_comb begin
    occ_nxt = occ_r;
    if (acc) begin
      unique case (kind)
        KIND_INSERT:  if (!full)  occ_nxt = occ_r + CNT_W'(1);
        KIND_POP_MIN: if (!empty) occ_nxt = occ_r - CNT_W'(1);
        KIND_POP_MAX: if (!empty) occ_nxt = occ_r - CNT_W'(1);
        KIND_SEARCH:  occ_nxt = occ_r;
        default:      occ_nxt = occ_r;
      endcase
    end
  end

  // cell row
  always_comb begin
    cmd         = '0;
    cmd.ins     = acc && kind == KIND_INSERT && !full;
    cmd.pop_min = acc && kind == KIND_POP_MIN && !empty;
    cmd.max     = kind == KIND_POP_MAX;
    cmd.srch    = kind == KIND_SEARCH;
    cmd.key     = in_ch.value;
    cmd.cnt     = occ_r;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry, right_entry;
    logic                      left_lt;

    if (i == 0) begin : g_first
      assign left_entry = cmd.key;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_lt    = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    sql_cell u_cell (
      .clk           (clk),
      .cmd_i         (cmd),
      .idx_i         (IDX_W'(i)),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .lt_o          (lt[i]),
      .red_o         (leaves[i])
    );
  end

  sql_reduce u_reduce (
    .clk    (clk),
    .load_i (load),
    .leaf_i (leaves),
    .root_o (red_root)
  );

  // results
  assign cnt_nxt_ext = {{COUNT_W{1'b0}}, occ_nxt};
  assign cnt_cur_ext = {{COUNT_W{1'b0}}, occ_r};
  assign pos_ext     = {{POS_W{1'b0}}, red_root.pos};

  always_comb begin
    imm       = '0;
    imm.count = cnt_nxt_ext[COUNT_W-1:0];
    unique case (kind)
      KIND_INSERT:  imm.status = full ? ST_FULL : ST_OK;
      KIND_POP_MIN: begin
        if (empty) begin
          imm.status = ST_EMPTY;
        end else begin
          imm.data = entry[0];
        end
      end
      KIND_POP_MAX: imm.status = empty ? ST_EMPTY : ST_OK;
      KIND_SEARCH:  imm.status = ST_MISS;
      default:      imm.status = ST_OK;
    endcase
  end

  always_comb begin
    red_res          = '0;
    red_res.count    = cnt_cur_ext[COUNT_W-1:0];
    red_res.data     = red_root.data;
    red_res.position = pos_ext[POS_W-1:0];
    if (is_max_r || red_root.hit) begin
      red_res.status = ST_OK;
    end else begin
      red_res.status = ST_MISS;
    end
  end

  always_comb begin
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !move;
    if (imm_take) begin
      res_nxt       = imm;
      res_valid_nxt = 1'b1;
    end else if (done) begin
      res_nxt       = red_res;
      res_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_nxt       = res_r;
      out_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      occ_r       <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      occ_r       <= occ_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_max_r <= is_max_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data     = out_r.data;
  assign out_ch.position = out_r.position;
  assign out_ch.status   = out_r.status;
  assign out_ch.count    = out_r.count;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_INSERT && full |=> occ_r == $past(occ_r))
    else $error("insert on full queue changed occupancy");

  a_busy_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REDUCE |-> !in_ready)
    else $error("item taken during reduction");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !move |=> res_valid_r && $stable(res_r))
    else $error("pending result lost");

  a_max_hit: assert property (@(posedge clk) disable iff (!rst_n)
    done && is_max_r |-> red_root.hit)
    else $error("pop largest found no last entry");

endmodule
